/* src/smpq_pkg.sv */
// Package for the sorted max priority queue: depth, widths and sequencer states.
// Used by sorted_max_priority_queue_unit; depends on nothing else.
`default_nettype none
package smpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS = 8;
    localparam int KEY_W = 24;
    localparam int TAG_PORT_W = 8;
    localparam int ENTRY_COUNT_W = 5;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_RM_RD,
        ST_RM_WR,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

/* src/sorted_max_priority_queue_unit.sv */
// Sorted max priority queue: top level with entry memory, compare/shift sequencer
// and output register. Depends on smpq_pkg.
//
// Usage:
//   Input channel s_*: one beat is one operation. s_action selects insert
//   (s_key, s_tag stored) or remove of the entry with the largest key.
//   Equal keys leave in arrival order. Result channel m_*: one beat per input
//   beat, in order, with the removed key and tag (zero on insert), the
//   empty and overflow flags and the entry count after the operation.
//   Sequencing: one operation at a time; one comparator and an index
//   counter walk a registered-read memory one slot at a time, a read state
//   then a compare (insert) or write (remove) state per slot. An insert
//   moves entries toward the tail until it finds its slot; a remove shifts
//   every remaining entry toward the head; a rejected or empty one goes
//   straight to the result. s_ready is high only while no operation is in
//   work, from the cycle after the result is loaded.
//   Reset (aresetn low, synchronous) empties the queue and drops any
//   pending result. When the receiver stalls, the result is held in the
//   output register; the next beat is accepted and worked on, and its
//   result waits until the register is free.
`default_nettype none
module sorted_max_priority_queue_unit
    import smpq_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_action,
    input  wire logic [KEY_W-1:0]         s_key,
    input  wire logic [TAG_PORT_W-1:0]    s_tag,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [KEY_W-1:0]              m_out_key,
    output logic [TAG_PORT_W-1:0]         m_out_tag,
    output logic                          m_was_empty,
    output logic                          m_overflow,
    output logic [ENTRY_COUNT_W-1:0]      m_entry_count
);

    logic [KEY_W-1:0]    key_mem [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] tag_mem [QUEUE_DEPTH];

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [KEY_W-1:0]    new_key_reg;
    logic [TAG_BITS-1:0] new_tag_reg;
    logic [KEY_W-1:0]    rd_key_reg;
    logic [TAG_BITS-1:0] rd_tag_reg;

    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [TAG_BITS-1:0] res_tag_reg, res_tag_next;
    logic                res_empty_reg, res_empty_next;
    logic                res_ovf_reg, res_ovf_next;

    logic                   out_valid_reg;
    logic [KEY_W-1:0]       out_key_reg;
    logic [TAG_PORT_W-1:0]  out_tag_reg;
    logic                   out_empty_reg;
    logic                   out_ovf_reg;
    logic [ENTRY_COUNT_W-1:0] out_count_reg;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [IDX_W-1:0]    mem_raddr;
    logic [KEY_W-1:0]    mem_wkey;
    logic [TAG_BITS-1:0] mem_wtag;

    logic             s_fire;
    logic             out_load;
    logic             key_ge;
    logic             q_full;
    logic             q_empty;
    logic [CNT_W-1:0] idx_dec;
    logic [CNT_W-1:0] idx_inc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);
    assign key_ge   = (rd_key_reg >= new_key_reg);
    assign q_full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty  = (count_reg == '0);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign idx_inc  = idx_reg + CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_action == ACT_INSERT) begin
                        state_next = q_full ? ST_DONE : ST_INS_RD;
                    end else begin
                        state_next = q_empty ? ST_DONE : ST_RM_RD;
                    end
                end
            end
            ST_INS_RD: begin
                state_next = (idx_reg == '0) ? ST_DONE : ST_INS_CMP;
            end
            ST_INS_CMP: begin
                state_next = key_ge ? ST_DONE : ST_INS_RD;
            end
            ST_RM_RD: begin
                state_next = ST_RM_WR;
            end
            ST_RM_WR: begin
                state_next = (idx_inc == count_reg) ? ST_DONE : ST_RM_RD;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[IDX_W-1:0];
        mem_raddr      = idx_reg[IDX_W-1:0];
        mem_wkey       = new_key_reg;
        mem_wtag       = new_tag_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        res_key_next   = res_key_reg;
        res_tag_next   = res_tag_reg;
        res_empty_next = res_empty_reg;
        res_ovf_next   = res_ovf_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    res_key_next   = '0;
                    res_tag_next   = '0;
                    res_empty_next = (s_action == ACT_REMOVE) && q_empty;
                    res_ovf_next   = (s_action == ACT_INSERT) && q_full;
                    idx_next       = (s_action == ACT_INSERT) ? count_reg : '0;
                end
            end
            ST_INS_RD: begin
                mem_raddr = idx_dec[IDX_W-1:0];
                if (idx_reg == '0) begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_INS_CMP: begin
                mem_we = 1'b1;
                if (key_ge) begin
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    mem_wkey = rd_key_reg;
                    mem_wtag = rd_tag_reg;
                    idx_next = idx_dec;
                end
            end
            ST_RM_RD: begin
            end
            ST_RM_WR: begin
                mem_waddr = idx_dec[IDX_W-1:0];
                mem_wkey  = rd_key_reg;
                mem_wtag  = rd_tag_reg;
                if (idx_reg == '0) begin
                    res_key_next = rd_key_reg;
                    res_tag_next = rd_tag_reg;
                end else begin
                    mem_we = 1'b1;
                end
                idx_next = idx_inc;
                if (idx_inc == count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[mem_waddr] <= mem_wkey;
            tag_mem[mem_waddr] <= mem_wtag;
        end
        rd_key_reg <= key_mem[mem_raddr];
        rd_tag_reg <= tag_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        res_key_reg   <= res_key_next;
        res_tag_reg   <= res_tag_next;
        res_empty_reg <= res_empty_next;
        res_ovf_reg   <= res_ovf_next;
        if (s_fire) begin
            new_key_reg <= s_key;
            new_tag_reg <= TAG_BITS'(s_tag);
        end
        if (out_load) begin
            out_key_reg   <= res_key_reg;
            out_tag_reg   <= TAG_PORT_W'(res_tag_reg);
            out_empty_reg <= res_empty_reg;
            out_ovf_reg   <= res_ovf_reg;
            out_count_reg <= ENTRY_COUNT_W'(count_reg);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_key     = out_key_reg;
    assign m_out_tag     = out_tag_reg;
    assign m_was_empty   = out_empty_reg;
    assign m_overflow    = out_ovf_reg;
    assign m_entry_count = out_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (CNT_W'(mem_waddr) <= count_reg))
        else $error("memory write beyond tail");

    a_ovf_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_ovf_reg) |-> q_full)
        else $error("overflow flagged with free slots");

    a_empty_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_empty_reg) |-> (q_empty && res_key_reg == '0))
        else $error("empty flagged on a filled queue");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !(res_empty_reg && res_ovf_reg))
        else $error("empty and overflow both set");

endmodule
`default_nettype wire

/* tb/queue_order_checker.sv */
// Checker for the sorted max priority queue: watches both channels, keeps a
// shadow copy of the sorted entries and compares every result beat.
// Depends on smpq_pkg.
module queue_order_checker
    import smpq_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire logic                     s_action,
    input  wire logic [KEY_W-1:0]         s_key,
    input  wire logic [TAG_PORT_W-1:0]    s_tag,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic [KEY_W-1:0]         m_out_key,
    input  wire logic [TAG_PORT_W-1:0]    m_out_tag,
    input  wire logic                     m_was_empty,
    input  wire logic                     m_overflow,
    input  wire logic [ENTRY_COUNT_W-1:0] m_entry_count,
    output int unsigned                   error_total,
    output int unsigned                   pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KEY_W-1:0]         out_key;
        logic [TAG_PORT_W-1:0]    out_tag;
        logic                     was_empty;
        logic                     overflow;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } queue_result_t;

    logic [KEY_W-1:0]      held_keys[QUEUE_DEPTH];
    logic [TAG_PORT_W-1:0] held_tags[QUEUE_DEPTH];
    int unsigned           held_count = 0;
    queue_result_t         predicted_results[$];

    function automatic queue_result_t predict_queue_op(input logic act,
            input logic [KEY_W-1:0] k, input logic [TAG_PORT_W-1:0] t);
        queue_result_t r;
        int unsigned slot;
        int unsigned i;
        r = '0;
        if (act == ACT_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                r.overflow = 1'b1;
            end else begin
                // place after every entry with a greater or equal key
                slot = 0;
                while (slot < held_count && held_keys[slot] >= k) slot++;
                for (i = held_count; i > slot; i--) begin
                    held_keys[i] = held_keys[i-1];
                    held_tags[i] = held_tags[i-1];
                end
                held_keys[slot] = k;
                held_tags[slot] = t[TAG_BITS-1:0];
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                r.was_empty = 1'b1;
            end else begin
                r.out_key = held_keys[0];
                r.out_tag = held_tags[0];
                for (i = 1; i < held_count; i++) begin
                    held_keys[i-1] = held_keys[i];
                    held_tags[i-1] = held_tags[i];
                end
                held_count--;
            end
        end
        r.entry_count = ENTRY_COUNT_W'(held_count);
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
            input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_total++;
        end
    endfunction

    always @(posedge aclk) begin : track
        queue_result_t want;
        if (!aresetn) begin
            held_count = 0;
            error_total = 0;
            predicted_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("result beat with no operation waiting");
                    error_total++;
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("out_key", 32'(want.out_key), 32'(m_out_key));
                    compare_field("out_tag", 32'(want.out_tag), 32'(m_out_tag));
                    compare_field("was_empty", 32'(want.was_empty), 32'(m_was_empty));
                    compare_field("overflow", 32'(want.overflow), 32'(m_overflow));
                    compare_field("entry_count", 32'(want.entry_count),
                                  32'(m_entry_count));
                end
            end
            if (s_valid && s_ready)
                predicted_results.push_back(predict_queue_op(s_action, s_key, s_tag));
        end
        pending_results <= predicted_results.size();
    end

endmodule

/* tb/sorted_max_priority_queue_unit_tb.sv */
// Testbench top for sorted_max_priority_queue_unit: clock, reset, operation
// stimulus, result-side backpressure, watchdog and verdict.
// Depends on smpq_pkg, sorted_max_priority_queue_unit and queue_order_checker.
module sorted_max_priority_queue_unit_tb;
    import smpq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 60;
    localparam int SEGMENTS        = 11;
    localparam int SEGMENT_BEATS   = 40;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_action = ACT_INSERT;
    logic [KEY_W-1:0]         s_key = '0;
    logic [TAG_PORT_W-1:0]    s_tag = '0;
    logic                     m_ready = 1'b0;
    logic                     s_ready;
    logic                     m_valid;
    logic [KEY_W-1:0]         m_out_key;
    logic [TAG_PORT_W-1:0]    m_out_tag;
    logic                     m_was_empty;
    logic                     m_overflow;
    logic [ENTRY_COUNT_W-1:0] m_entry_count;

    int unsigned error_total;
    int unsigned pending_results;
    int unsigned quiet_cycles = 0;
    bit          idle_on = 1'b1;
    bit          hold_request = 1'b0;

    always #5 aclk = ~aclk;

    sorted_max_priority_queue_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_key         (s_key),
        .s_tag         (s_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_key     (m_out_key),
        .m_out_tag     (m_out_tag),
        .m_was_empty   (m_was_empty),
        .m_overflow    (m_overflow),
        .m_entry_count (m_entry_count)
    );

    queue_order_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_key           (s_key),
        .s_tag           (s_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_key       (m_out_key),
        .m_out_tag       (m_out_tag),
        .m_was_empty     (m_was_empty),
        .m_overflow      (m_overflow),
        .m_entry_count   (m_entry_count),
        .error_total     (error_total),
        .pending_results (pending_results)
    );

    task automatic send_beat(input logic act, input logic [KEY_W-1:0] k,
            input logic [TAG_PORT_W-1:0] t);
        while (idle_on && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_key    <= k;
        s_tag    <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(3))
            0: return KEY_W'($urandom_range(7) * 100);
            1: return $urandom_range(1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
            default: return KEY_W'($urandom);
        endcase
    endfunction

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= !(idle_on && $urandom_range(99) < 38);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned insert_pct;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(ACT_REMOVE, '0, '0);
        send_beat(ACT_INSERT, {KEY_W{1'b1}}, 8'hFF);
        send_beat(ACT_INSERT, '0, 8'h00);
        send_beat(ACT_INSERT, {KEY_W{1'b1}}, 8'h01);
        send_beat(ACT_INSERT, 24'h800000, 8'hAA);
        send_beat(ACT_INSERT, 24'h7FFFFF, 8'h55);
        send_beat(ACT_INSERT, '0, 8'h3C);
        for (int n = 0; n < 10; n++)
            send_beat(ACT_INSERT, KEY_W'($urandom), TAG_PORT_W'($urandom));
        send_beat(ACT_INSERT, 24'h123456, 8'h77);
        send_beat(ACT_REMOVE, {KEY_W{1'b1}}, 8'hFF);
        send_beat(ACT_INSERT, {KEY_W{1'b1}}, 8'hC3);
        send_beat(ACT_INSERT, '0, 8'h99);

        // alternate fill-heavy and drain-heavy segments
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            insert_pct = (seg % 2 == 0) ? 75 : 25;
            idle_on = (seg != 3 && seg != 5);
            if (seg == 5)
                hold_request = 1'b1;
            if (seg == 7)
                wait_for_drain();
            repeat (SEGMENT_BEATS) begin
                send_beat(($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE,
                          pick_key(), TAG_PORT_W'($urandom));
            end
        end

        idle_on = 1'b1;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_total == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
